// ----- hdl/lps_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Lottery scheduler package
// Shared constants, function codes and the controller/datapath link types.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int unsigned MaxProcs     = 16;
  localparam int unsigned LotterySlots = 100;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned PtrW    = 48;
  localparam int unsigned PidW    = 16;
  localparam int unsigned TicketW = 16;
  localparam int unsigned DrawW   = 16;
  localparam int unsigned StatusW = 2;

  localparam logic [FuncW-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FuncW-1:0] FUNC_SWITCH = 2'd1;
  localparam logic [FuncW-1:0] FUNC_FINISH = 2'd2;
  localparam logic [FuncW-1:0] FUNC_UNUSED = 2'd3;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;     // capture the input transaction
    logic do_add;       // append a new entry
    logic save_sp;      // save stack pointer of running entry
    logic del_start;    // begin removal of running entry
    logic del_step;     // move one entry down
    logic del_end;      // finish removal
    logic rb_start;     // begin slot rebuild
    logic div_start;    // begin share division for current entry
    logic div_step;     // one quotient bit
    logic fill_step;    // write one slot
    logic rb_next;      // advance to next entry
    logic rb_end;       // commit slot count
    logic mod_start;    // begin draw mod slots_used
    logic mod_step;     // one remainder bit
    logic rd_slot;      // read slot owner
    logic first_pick;   // dispatch entry 0
    logic set_win;      // take slot owner as winner
    logic set_empty;    // no process: clear first_done
    logic out_full;     // result: table full
    logic out_add;      // result: add
    logic out_empty;    // result: no process
    logic out_win;      // result: chosen entry
  } lps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [FuncW-1:0] func;
    logic full;
    logic empty;
    logic first_done;
    logic run_live;
    logic del_more;
    logic rb_more;
    logic div_done;
    logic fill_more;
    logic mod_done;
    logic slots_zero;
    logic live_zero;
  } lps_sts_t;

endpackage
`default_nettype wire

// ----- hdl/lps_stream_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Lottery scheduler channel interfaces
// Valid/ready channels for the request and result transactions.
// ----------------------------------------------------------------------------
interface lps_req_if;
  logic                               valid;
  logic                               ready;
  logic [lps_pkg::FuncW-1:0]          func;
  logic [lps_pkg::PtrW-1:0]           stack_ptr;
  logic [lps_pkg::TicketW-1:0]        tickets;
  logic [lps_pkg::DrawW-1:0]          draw;
  modport source (output valid, func, stack_ptr, tickets, draw, input ready);
  modport sink   (input valid, func, stack_ptr, tickets, draw, output ready);
endinterface

interface lps_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [lps_pkg::PtrW-1:0]           resume_ptr;
  logic [lps_pkg::PidW-1:0]           chosen_pid;
  logic [lps_pkg::StatusW-1:0]        status;
  modport source (output valid, resume_ptr, chosen_pid, status, input ready);
  modport sink   (input valid, resume_ptr, chosen_pid, status, output ready);
endinterface
`default_nettype wire

// ----- hdl/lps_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Lottery scheduler generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module lps_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- hdl/lps_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Lottery scheduler datapath
// Process table, slot table, serial divider and result register.
// ----------------------------------------------------------------------------
module lps_datapath #(
  parameter int unsigned MaxProcs     = lps_pkg::MaxProcs,
  parameter int unsigned LotterySlots = lps_pkg::LotterySlots
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lps_pkg::lps_cmd_t cmd_i,
  output      lps_pkg::lps_sts_t sts_o,
  lps_req_if.sink               req,
  lps_rsp_if.source             rsp
);

  localparam int unsigned IdxW  = $clog2(MaxProcs);
  localparam int unsigned CntW  = $clog2(MaxProcs + 1);
  localparam int unsigned SlotW = $clog2(LotterySlots);
  localparam int unsigned SCntW = $clog2(LotterySlots + 1);
  localparam int unsigned TotW  = lps_pkg::TicketW + CntW;
  // Numerator weight * slots.
  localparam int unsigned NumW  = lps_pkg::TicketW + SCntW;
  localparam int unsigned StepW = $clog2(NumW + 1);
  localparam int unsigned MCntW = $clog2(lps_pkg::DrawW + 1);

  // Captured request.
  logic [lps_pkg::FuncW-1:0]   func_q;
  logic [lps_pkg::PtrW-1:0]    sp_q;
  logic [lps_pkg::TicketW-1:0] tick_q;
  logic [lps_pkg::DrawW-1:0]   draw_q;

  logic [CntW-1:0]  live_q;
  logic [TotW-1:0]  total_q;
  logic [SCntW-1:0] used_q;
  logic [IdxW-1:0]  run_q;
  logic [lps_pkg::PidW-1:0] pidc_q;
  logic             first_q;

  // Entry table in flip-flops (shifted on delete).
  logic [lps_pkg::PidW-1:0]    pid_q   [MaxProcs];
  logic [lps_pkg::TicketW-1:0] wgt_q   [MaxProcs];
  logic [lps_pkg::PtrW-1:0]    stk_q   [MaxProcs];

  logic [CntW-1:0]  ptr_q;      // delete / rebuild entry pointer
  logic [NumW-1:0]  dnum_q;
  logic [TotW:0]    drem_q;
  logic [NumW-1:0]  dquo_q;
  logic [StepW-1:0] dcnt_q;
  logic [NumW-1:0]  share_q;
  logic [SCntW-1:0] fill_q;
  logic [IdxW-1:0]  win_q;

  logic [lps_pkg::DrawW-1:0] mnum_q;
  logic [SCntW:0]            mrem_q;
  logic [MCntW-1:0]          mcnt_q;

  logic [IdxW-1:0] owner_rd;
  logic [TotW:0]   drem_sh;
  logic [SCntW:0]  mrem_sh;
  logic [IdxW-1:0] ptr_idx;
  logic [IdxW-1:0] ptr_nxt;
  logic            out_cmd;
  logic            out_v_q;

  // Slot owner memory.
  lps_ram #(.Width(IdxW), .Depth(LotterySlots)) u_slots (
    .clk_i  (clk_i),
    .we_i   (cmd_i.fill_step),
    .waddr_i(fill_q[SlotW-1:0]),
    .wdata_i(ptr_idx),
    .raddr_i(mrem_q[SlotW-1:0]),
    .rdata_o(owner_rd)
  );

  assign drem_sh = {drem_q[TotW-1:0], dnum_q[NumW-1]};
  assign mrem_sh = {mrem_q[SCntW-1:0], mnum_q[lps_pkg::DrawW-1]};
  assign ptr_idx = ptr_q[IdxW-1:0];
  assign ptr_nxt = ptr_idx + IdxW'(1);
  assign out_cmd = cmd_i.out_full || cmd_i.out_add || cmd_i.out_empty || cmd_i.out_win;

  // Status toward the controller.
  always_comb begin
    sts_o            = '0;
    sts_o.func       = func_q;
    sts_o.full       = (live_q >= CntW'(MaxProcs));
    sts_o.empty      = (live_q == '0);
    sts_o.first_done = first_q;
    sts_o.run_live   = (CntW'(run_q) < live_q);
    sts_o.del_more   = (ptr_q + CntW'(1) < live_q);
    sts_o.rb_more    = (ptr_q < live_q);
    sts_o.div_done   = (dcnt_q == '0);
    sts_o.fill_more  = (share_q != '0) && (fill_q < SCntW'(LotterySlots));
    sts_o.mod_done   = (mcnt_q == '0);
    sts_o.slots_zero = (used_q == '0);
    sts_o.live_zero  = (live_q == '0);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q  <= '0;
      total_q <= '0;
      used_q  <= '0;
      run_q   <= '0;
      pidc_q  <= '0;
      first_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (out_cmd) begin
        out_v_q <= 1'b1;
      end else if (rsp.ready) begin
        out_v_q <= 1'b0;
      end
      if (cmd_i.do_add) begin
        live_q  <= live_q + CntW'(1);
        total_q <= total_q + TotW'(tick_q);
        pidc_q  <= (pidc_q == '1) ? lps_pkg::PidW'(1) : pidc_q + lps_pkg::PidW'(1);
      end
      if (cmd_i.del_start) begin
        total_q <= total_q - TotW'(wgt_q[run_q]);
      end
      if (cmd_i.del_end) begin
        live_q <= live_q - CntW'(1);
      end
      if (cmd_i.rb_end) begin
        used_q <= fill_q;
      end
      if (cmd_i.first_pick) begin
        first_q <= 1'b1;
        run_q   <= '0;
      end
      if (cmd_i.set_win) begin
        run_q <= win_q;
      end
      if (cmd_i.set_empty) begin
        first_q <= 1'b0;
        run_q   <= '0;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      func_q <= req.func;
      sp_q   <= req.stack_ptr;
      tick_q <= req.tickets;
      draw_q <= req.draw;
    end
    if (cmd_i.do_add) begin
      pid_q[live_q[IdxW-1:0]] <= (pidc_q == '1) ? lps_pkg::PidW'(1)
                                                : pidc_q + lps_pkg::PidW'(1);
      wgt_q[live_q[IdxW-1:0]] <= tick_q;
      stk_q[live_q[IdxW-1:0]] <= sp_q;
    end
    if (cmd_i.save_sp) begin
      stk_q[run_q] <= sp_q;
    end
    if (cmd_i.del_start) begin
      ptr_q <= CntW'(run_q);
    end
    if (cmd_i.del_step) begin
      pid_q[ptr_idx] <= pid_q[ptr_nxt];
      wgt_q[ptr_idx] <= wgt_q[ptr_nxt];
      stk_q[ptr_idx] <= stk_q[ptr_nxt];
      ptr_q          <= ptr_q + CntW'(1);
    end
    if (cmd_i.rb_start) begin
      ptr_q  <= '0;
      fill_q <= '0;
    end
    // Restoring divider: weight * slots / total, one bit per cycle.
    if (cmd_i.div_start) begin
      dnum_q <= NumW'(wgt_q[ptr_idx]) * NumW'(LotterySlots);
      drem_q <= '0;
      dquo_q <= '0;
      dcnt_q <= StepW'(NumW);
    end
    if (cmd_i.div_step) begin
      dnum_q <= dnum_q << 1;
      dcnt_q <= dcnt_q - StepW'(1);
      if (drem_sh >= {1'b0, total_q}) begin
        drem_q <= drem_sh - {1'b0, total_q};
        dquo_q <= {dquo_q[NumW-2:0], 1'b1};
      end else begin
        drem_q <= drem_sh;
        dquo_q <= {dquo_q[NumW-2:0], 1'b0};
      end
      if (dcnt_q == StepW'(1)) begin
        // Final bit: round half up using the remainder.
        if (total_q == '0) begin
          share_q <= '0;
        end else if (drem_sh >= {1'b0, total_q}) begin
          share_q <= {dquo_q[NumW-2:0], 1'b1}
                   + NumW'((({drem_sh - {1'b0, total_q}, 1'b0}) >= {2'b0, total_q}));
        end else begin
          share_q <= {dquo_q[NumW-2:0], 1'b0}
                   + NumW'(({drem_sh, 1'b0} >= {2'b0, total_q}));
        end
      end
    end
    if (cmd_i.fill_step) begin
      fill_q  <= fill_q + SCntW'(1);
      share_q <= share_q - NumW'(1);
    end
    if (cmd_i.rb_next) begin
      ptr_q <= ptr_q + CntW'(1);
    end
    // Draw mod slots_used, one bit per cycle.
    if (cmd_i.mod_start) begin
      mnum_q <= draw_q;
      mrem_q <= '0;
      mcnt_q <= MCntW'(lps_pkg::DrawW);
    end
    if (cmd_i.mod_step) begin
      mnum_q <= mnum_q << 1;
      mcnt_q <= mcnt_q - MCntW'(1);
      mrem_q <= (mrem_sh >= {1'b0, used_q}) ? mrem_sh - {1'b0, used_q} : mrem_sh;
    end
    // The winner is the slot owner, else entry 0 (first dispatch, no slots, stale owner).
    if (cmd_i.rd_slot) begin
      win_q <= (used_q == '0 || CntW'(owner_rd) >= live_q) ? '0 : owner_rd;
    end
    if (cmd_i.first_pick) begin
      win_q <= '0;
    end
    // Result register.
    if (cmd_i.out_full) begin
      rsp.resume_ptr <= '0;
      rsp.chosen_pid <= '0;
      rsp.status     <= lps_pkg::ST_FULL;
    end
    if (cmd_i.out_add) begin
      rsp.resume_ptr <= sp_q;
      rsp.chosen_pid <= pidc_q;
      rsp.status     <= lps_pkg::ST_OK;
    end
    if (cmd_i.out_empty) begin
      rsp.resume_ptr <= sp_q;
      rsp.chosen_pid <= '0;
      rsp.status     <= lps_pkg::ST_EMPTY;
    end
    if (cmd_i.out_win) begin
      rsp.resume_ptr <= stk_q[win_q];
      rsp.chosen_pid <= pid_q[win_q];
      rsp.status     <= lps_pkg::ST_OK;
    end
  end

  assign rsp.valid = out_v_q;

  // The slot count never exceeds the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= SCntW'(LotterySlots))
    else $error("slot count beyond table");

  // The live count never exceeds the process table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CntW'(MaxProcs))
    else $error("live count beyond table");

  // An add or winner result write happens only while the output register is free or draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_add || cmd_i.out_win) |-> (!out_v_q || rsp.ready))
    else $error("result overwritten");

endmodule
`default_nettype wire

// ----- hdl/lps_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Lottery scheduler controller
// Sequences add, delete, slot rebuild, draw reduction and dispatch.
// ----------------------------------------------------------------------------
module lps_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire logic              out_busy_i,
  input  wire lps_pkg::lps_sts_t sts_i,
  output      lps_pkg::lps_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_DEL    = 4'd2;
  localparam logic [3:0] S_RB     = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_FILL   = 4'd5;
  localparam logic [3:0] S_POST   = 4'd6;
  localparam logic [3:0] S_MOD    = 4'd7;
  localparam logic [3:0] S_RD     = 4'd8;
  localparam logic [3:0] S_RDW    = 4'd9;
  localparam logic [3:0] S_WIN    = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;
  localparam logic [3:0] S_MODS   = 4'd12;

  logic [3:0] state_q, state_d;
  logic       wait_out;

  assign in_ready_o = (state_q == S_IDLE);
  assign wait_out   = out_busy_i;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DEC;
        end
      end
      S_DEC: begin
        if (!wait_out) begin
          if (sts_i.func == lps_pkg::FUNC_ADD) begin
            if (sts_i.full) begin
              cmd_o.out_full = 1'b1;
              state_d        = S_IDLE;
            end else begin
              cmd_o.do_add = 1'b1;
              state_d      = S_RB;
            end
          end else if (sts_i.empty) begin
            cmd_o.set_empty = 1'b1;
            cmd_o.out_empty = 1'b1;
            state_d         = S_IDLE;
          end else if (!sts_i.first_done) begin
            cmd_o.first_pick = 1'b1;
            state_d          = S_OUT;
          end else if (sts_i.func == lps_pkg::FUNC_FINISH) begin
            if (sts_i.run_live) begin
              cmd_o.del_start = 1'b1;
              state_d         = S_DEL;
            end else begin
              state_d = S_MODS;
            end
          end else begin
            cmd_o.save_sp = sts_i.run_live;
            state_d       = S_MODS;
          end
        end
      end
      S_DEL: begin
        if (sts_i.del_more) begin
          cmd_o.del_step = 1'b1;
        end else begin
          cmd_o.del_end = 1'b1;
          state_d       = S_RB;
        end
      end
      S_RB: begin
        cmd_o.rb_start = 1'b1;
        state_d        = S_POST;
      end
      S_POST: begin
        if (sts_i.rb_more) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          cmd_o.rb_end = 1'b1;
          state_d      = S_WIN;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_FILL;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_FILL: begin
        if (sts_i.fill_more) begin
          cmd_o.fill_step = 1'b1;
        end else begin
          cmd_o.rb_next = 1'b1;
          state_d       = S_POST;
        end
      end
      S_WIN: begin
        // After a rebuild: add reports, finish dispatches or reports that no process is left.
        if (sts_i.func == lps_pkg::FUNC_ADD) begin
          cmd_o.out_add = 1'b1;
          state_d       = S_IDLE;
        end else if (sts_i.live_zero) begin
          cmd_o.set_empty = 1'b1;
          cmd_o.out_empty = 1'b1;
          state_d         = S_IDLE;
        end else begin
          state_d = S_MODS;
        end
      end
      S_MODS: begin
        cmd_o.mod_start = 1'b1;
        state_d         = sts_i.slots_zero ? S_RD : S_MOD;
      end
      S_MOD: begin
        if (sts_i.mod_done) begin
          state_d = S_RD;
        end else begin
          cmd_o.mod_step = 1'b1;
        end
      end
      S_RD: begin
        state_d = S_RDW;
      end
      S_RDW: begin
        cmd_o.rd_slot = 1'b1;
        state_d       = S_OUT;
      end
      S_OUT: begin
        // Make the winner the running entry and report it.
        cmd_o.set_win = 1'b1;
        cmd_o.out_win = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Only one item is in flight: no acceptance outside idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE)
    else $error("accept outside idle");

  // A new item is always decoded next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == S_DEC)
    else $error("decode skipped");

  // Delete steps stay inside the delete state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.del_step |-> state_q == S_DEL)
    else $error("stray delete step");

endmodule
`default_nettype wire

// ----- hdl/lottery_process_scheduler.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Lottery process scheduler
// Process table with ticket-weighted lottery dispatch.
// ----------------------------------------------------------------------------
// After acceptance: a full table or no-process result is written from decode;
//   a switch first runs the serial draw reduction (1 bit/cycle).
// Add, and finish of a live entry, rebuild the slot table: 23 divider steps
//   per process, then one slot written per cycle.
// One transaction at a time; a result still waiting holds the next decode.
// Reset (asynchronous, active low) empties the process table and slot count.
module lottery_process_scheduler #(
  parameter int unsigned MaxProcs     = lps_pkg::MaxProcs,
  parameter int unsigned LotterySlots = lps_pkg::LotterySlots
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lps_req_if.sink   req,
  lps_rsp_if.source rsp
);

  lps_pkg::lps_cmd_t cmd;
  lps_pkg::lps_sts_t sts;

  lps_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(req.valid),
    .in_ready_o(req.ready),
    .out_busy_i(rsp.valid && !rsp.ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  lps_datapath #(.MaxProcs(MaxProcs), .LotterySlots(LotterySlots)) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .sts_o (sts),
    .req   (req),
    .rsp   (rsp)
  );

endmodule
`default_nettype wire
